// File: hw/rtl/kpl_pkg.sv
package kpl_pkg;

  // Operation codes of an input item
  typedef enum logic [1:0] {
    OP_KEY     = 2'd0,
    OP_SESSION = 2'd1,
    OP_SLEEP   = 2'd2,
    OP_UNUSED  = 2'd3
  } op_e;

  // Result event codes
  typedef enum logic [3:0] {
    EV_NONE    = 4'd0,
    EV_STORED  = 4'd1,
    EV_ERASED  = 4'd2,
    EV_OK      = 4'd3,
    EV_WRONG   = 4'd4,
    EV_LOCKED  = 4'd5,
    EV_FACE    = 4'd6,
    EV_FINGER  = 4'd7,
    EV_WOKE    = 4'd8,
    EV_ABORT   = 4'd9
  } ev_e;

  // Configuration register indexes
  typedef enum logic [1:0] {
    CFG_ENABLE     = 2'd0,
    CFG_PIN_VALUE  = 2'd1,
    CFG_PIN_LENGTH = 2'd2,
    CFG_TRY_LIMIT  = 2'd3
  } cfg_idx_e;

  localparam logic [7:0] KEY_NONE  = 8'h00;
  localparam logic [7:0] KEY_HASH  = 8'h23;
  localparam logic [7:0] KEY_STAR  = 8'h2A;
  localparam logic [7:0] KEY_A     = 8'h41;
  localparam logic [7:0] KEY_B     = 8'h42;
  localparam logic [7:0] KEY_C     = 8'h43;
  localparam logic [7:0] KEY_D     = 8'h44;

  localparam logic [3:0] ATTEMPT_SAT      = 4'd15;
  localparam logic [31:0] PIN_VALUE_RST   = 32'd0;
  localparam logic [2:0] PIN_LENGTH_RST   = 3'd4;
  localparam logic [3:0] TRY_LIMIT_RST    = 4'd3;

  typedef struct packed {
    logic [1:0] operation;
    logic [7:0] key;
  } in_item_t;

  typedef struct packed {
    logic [3:0] event_res;
    logic [2:0] entry_length;
    logic [3:0] tries_left;
  } out_item_t;

  typedef struct packed {
    logic        enable;
    logic [31:0] pin_value;
    logic [2:0]  pin_length;
    logic [3:0]  try_limit;
  } cfg_t;

endpackage

// File: hw/rtl/kpl_in_stage.sv
module kpl_in_stage (
  input  logic               clk_i,
  input  logic               rst_ni,
  input  logic               in_valid_i,
  output logic               in_ready_o,
  input  kpl_pkg::in_item_t  in_item_i,
  input  logic               pop_i,
  output logic               valid_o,
  output kpl_pkg::in_item_t  item_o
);

  logic              valid_q, valid_d;
  kpl_pkg::in_item_t item_q;

  assign in_ready_o = !valid_q || pop_i;
  assign valid_d    = in_ready_o ? in_valid_i : valid_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      valid_q <= 1'b0;
    end else begin
      valid_q <= valid_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (in_valid_i && in_ready_o) begin
      item_q <= in_item_i;
    end
  end

  assign valid_o = valid_q;
  assign item_o  = item_q;

endmodule

// File: hw/rtl/kpl_fsm.sv
module kpl_fsm #(
  parameter int unsigned MAX_DIGITS = 4
) (
  input  logic               clk_i,
  input  logic               rst_ni,
  input  kpl_pkg::cfg_t      cfg_i,
  input  logic               step_i,
  input  kpl_pkg::in_item_t  item_i,
  output kpl_pkg::out_item_t res_o
);

  localparam int unsigned CW   = $clog2(MAX_DIGITS + 1);
  localparam int unsigned IW   = (MAX_DIGITS > 1) ? $clog2(MAX_DIGITS) : 1;
  localparam int unsigned CMPW = (CW > 3) ? CW : 3;

  typedef enum logic [3:0] {
    PH_IDLE   = 4'b0001,
    PH_ENTRY  = 4'b0010,
    PH_DONE   = 4'b0100,
    PH_LOCKED = 4'b1000
  } phase_e;

  function automatic logic [7:0] pin_byte(logic [31:0] v, int unsigned i);
    logic [31:0] sh;
    sh = v >> (8 * i);
    return sh[7:0];
  endfunction

  phase_e          phase_q, phase_d;
  logic [CW-1:0]   cnt_q, cnt_d;
  logic [3:0]      att_q, att_d;
  logic            asleep_q, asleep_d;
  logic [7:0]      buf_q [MAX_DIGITS];

  logic            wr_en;
  logic [IW-1:0]   wr_idx;
  logic            match;
  logic [3:0]      att_inc;
  kpl_pkg::ev_e    ev;
  logic [7:0]      key;

  assign key = item_i.key;

  // Entry equals stored PIN, length included
  always_comb begin
    match = (CMPW'(cnt_q) == CMPW'(cfg_i.pin_length));
    for (int unsigned i = 0; i < MAX_DIGITS; i++) begin
      if ((CW'(i) < cnt_q) && (buf_q[i] != pin_byte(cfg_i.pin_value, i))) begin
        match = 1'b0;
      end
    end
  end

  assign att_inc = (att_q < kpl_pkg::ATTEMPT_SAT) ? att_q + 4'd1 : att_q;

  always_comb begin
    phase_d  = phase_q;
    cnt_d    = cnt_q;
    att_d    = att_q;
    asleep_d = asleep_q;
    wr_en    = 1'b0;
    wr_idx   = IW'(cnt_q);
    ev       = kpl_pkg::EV_NONE;
    if (cfg_i.enable) begin
      case (kpl_pkg::op_e'(item_i.operation))
        kpl_pkg::OP_SESSION: begin
          att_d   = '0;
          cnt_d   = '0;
          phase_d = PH_IDLE;
        end
        kpl_pkg::OP_SLEEP: begin
          asleep_d = 1'b1;
          if (phase_q == PH_ENTRY) begin
            cnt_d   = '0;
            phase_d = PH_IDLE;
            ev      = kpl_pkg::EV_ABORT;
          end
        end
        kpl_pkg::OP_KEY: begin
          if (key != kpl_pkg::KEY_NONE) begin
            if (asleep_q) begin
              asleep_d = 1'b0;
              ev       = kpl_pkg::EV_WOKE;
            end else begin
              unique case (phase_q)
                PH_IDLE: begin
                  if (key == kpl_pkg::KEY_D) begin
                    ev = kpl_pkg::EV_FACE;
                  end else if (key == kpl_pkg::KEY_C) begin
                    ev = kpl_pkg::EV_FINGER;
                  end else if (key != kpl_pkg::KEY_HASH && key != kpl_pkg::KEY_STAR &&
                               key != kpl_pkg::KEY_A && key != kpl_pkg::KEY_B) begin
                    wr_en   = 1'b1;
                    wr_idx  = '0;
                    cnt_d   = CW'(1);
                    phase_d = PH_ENTRY;
                    ev      = kpl_pkg::EV_STORED;
                  end
                end
                PH_ENTRY: begin
                  if (key == kpl_pkg::KEY_HASH) begin
                    if (cnt_q != '0) begin
                      cnt_d = '0;
                      if (match) begin
                        phase_d = PH_DONE;
                        ev      = kpl_pkg::EV_OK;
                      end else begin
                        att_d = att_inc;
                        if (att_inc >= cfg_i.try_limit) begin
                          phase_d = PH_LOCKED;
                          ev      = kpl_pkg::EV_LOCKED;
                        end else begin
                          phase_d = PH_IDLE;
                          ev      = kpl_pkg::EV_WRONG;
                        end
                      end
                    end
                  end else if (key == kpl_pkg::KEY_STAR) begin
                    if (cnt_q != '0) begin
                      cnt_d = cnt_q - CW'(1);
                      ev    = kpl_pkg::EV_ERASED;
                    end
                  end else if (key < kpl_pkg::KEY_A || key > kpl_pkg::KEY_D) begin
                    if (cnt_q < CW'(MAX_DIGITS)) begin
                      wr_en = 1'b1;
                      cnt_d = cnt_q + CW'(1);
                      ev    = kpl_pkg::EV_STORED;
                    end
                  end
                end
                PH_DONE, PH_LOCKED: begin
                  ev = kpl_pkg::EV_NONE;
                end
                default: begin
                  ev = kpl_pkg::EV_NONE;
                end
              endcase
            end
          end
        end
        default: begin
          ev = kpl_pkg::EV_NONE;
        end
      endcase
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      phase_q  <= PH_IDLE;
      cnt_q    <= '0;
      att_q    <= '0;
      asleep_q <= 1'b0;
    end else if (step_i) begin
      phase_q  <= phase_d;
      cnt_q    <= cnt_d;
      att_q    <= att_d;
      asleep_q <= asleep_d;
    end
  end

  for (genvar g = 0; g < MAX_DIGITS; g++) begin : g_buf
    always_ff @(posedge clk_i) begin
      if (step_i && wr_en && (wr_idx == IW'(g))) begin
        buf_q[g] <= key;
      end
    end
  end

  assign res_o.event_res    = ev;
  assign res_o.entry_length = 3'(cnt_d);
  assign res_o.tries_left   = (cfg_i.try_limit > att_d) ? cfg_i.try_limit - att_d : 4'd0;

endmodule

// File: hw/rtl/kpl_out_stage.sv
module kpl_out_stage (
  input  logic               clk_i,
  input  logic               rst_ni,
  input  logic               push_i,
  input  kpl_pkg::out_item_t res_i,
  output logic               can_push_o,
  output logic               out_valid_o,
  input  logic               out_ready_i,
  output kpl_pkg::out_item_t out_item_o
);

  logic               valid_q, valid_d;
  kpl_pkg::out_item_t res_q;

  assign can_push_o = !valid_q || out_ready_i;

  always_comb begin
    valid_d = valid_q;
    if (push_i) begin
      valid_d = 1'b1;
    end else if (out_ready_i) begin
      valid_d = 1'b0;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      valid_q <= 1'b0;
    end else begin
      valid_q <= valid_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (push_i) begin
      res_q <= res_i;
    end
  end

  assign out_valid_o = valid_q;
  assign out_item_o  = res_q;

endmodule

// File: hw/rtl/keypad_pin_entry_lock_core.sv
// Each item passes the input register, then the result register; it waits in the input
// register while the result register is full and not being drained.
// Throughput: one item per cycle unless the output stalls; each item yields exactly one result transaction.
// Per-key decision and full PIN compare sit between the input and result registers.
// Reset (async, active low): idle, no entry, no attempts, awake, both stages empty;
// config resets to enable 0, PIN 0, length 4, try limit 3. Entry buffer is not reset.
module keypad_pin_entry_lock_core #(
  parameter int unsigned MAX_DIGITS = 4
) (
  input  logic               clk_i,
  input  logic               rst_ni,
  input  logic               in_valid_i,
  output logic               in_ready_o,
  input  kpl_pkg::in_item_t  in_item_i,
  output logic               out_valid_o,
  input  logic               out_ready_i,
  output kpl_pkg::out_item_t out_item_o,
  input  logic               cfg_valid_i,
  output logic               cfg_ready_o,
  input  logic [1:0]         cfg_index_i,
  input  logic [31:0]        cfg_data_i
);

  kpl_pkg::cfg_t      cfg_q;
  logic               item_valid;
  kpl_pkg::in_item_t  item;
  logic               can_push;
  logic               step;
  kpl_pkg::out_item_t res;

  assign cfg_ready_o = 1'b1;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cfg_q.enable     <= 1'b0;
      cfg_q.pin_value  <= kpl_pkg::PIN_VALUE_RST;
      cfg_q.pin_length <= kpl_pkg::PIN_LENGTH_RST;
      cfg_q.try_limit  <= kpl_pkg::TRY_LIMIT_RST;
    end else if (cfg_valid_i) begin
      unique case (kpl_pkg::cfg_idx_e'(cfg_index_i))
        kpl_pkg::CFG_ENABLE:     cfg_q.enable     <= cfg_data_i[0];
        kpl_pkg::CFG_PIN_VALUE:  cfg_q.pin_value  <= cfg_data_i;
        kpl_pkg::CFG_PIN_LENGTH: cfg_q.pin_length <= cfg_data_i[2:0];
        kpl_pkg::CFG_TRY_LIMIT:  cfg_q.try_limit  <= cfg_data_i[3:0];
        default: begin
          cfg_q.enable <= cfg_q.enable;
        end
      endcase
    end
  end

  // An item is processed when the result register can take it
  assign step = item_valid && can_push;

  kpl_in_stage u_in_stage (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .in_valid_i (in_valid_i),
    .in_ready_o (in_ready_o),
    .in_item_i  (in_item_i),
    .pop_i      (step),
    .valid_o    (item_valid),
    .item_o     (item)
  );

  kpl_fsm #(
    .MAX_DIGITS (MAX_DIGITS)
  ) u_fsm (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .cfg_i  (cfg_q),
    .step_i (step),
    .item_i (item),
    .res_o  (res)
  );

  kpl_out_stage u_out_stage (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .push_i      (step),
    .res_i       (res),
    .can_push_o  (can_push),
    .out_valid_o (out_valid_o),
    .out_ready_i (out_ready_i),
    .out_item_o  (out_item_o)
  );

endmodule

// File: hw/rtl/kpl_checker.sv
module kpl_checker (
  input logic               clk_i,
  input logic               rst_ni,
  input logic               out_valid_o,
  input logic               out_ready_i,
  input kpl_pkg::out_item_t out_item_o
);

  // Stalled result transaction holds
  a_out_hold: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && !out_ready_i |=> out_valid_o && $stable(out_item_o))
    else $error("result changed while stalled");

  // Compare, abort and wake all leave the entry empty
  a_entry_cleared: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && (out_item_o.event_res == kpl_pkg::EV_OK ||
                    out_item_o.event_res == kpl_pkg::EV_WRONG ||
                    out_item_o.event_res == kpl_pkg::EV_LOCKED ||
                    out_item_o.event_res == kpl_pkg::EV_ABORT ||
                    out_item_o.event_res == kpl_pkg::EV_WOKE)
    |-> out_item_o.entry_length == 3'd0)
    else $error("entry not cleared");

  a_stored_nonempty: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && out_item_o.event_res == kpl_pkg::EV_STORED
    |-> out_item_o.entry_length != 3'd0)
    else $error("stored key but entry empty");

  a_locked_no_tries: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && out_item_o.event_res == kpl_pkg::EV_LOCKED
    |-> out_item_o.tries_left == 4'd0)
    else $error("locked with tries left");

  a_wrong_has_tries: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && out_item_o.event_res == kpl_pkg::EV_WRONG
    |-> out_item_o.tries_left != 4'd0)
    else $error("wrong without tries left");

endmodule

bind keypad_pin_entry_lock_core kpl_checker u_kpl_checker (.*);

// File: tb/tb_top.sv
`timescale 1ns / 100ps

module tb_top;

  localparam int DIGITS = 4;
  localparam int LIMIT = 500000;
  localparam int SETTLE = 6;

  typedef enum logic [1:0] {
    ST_IDLE   = 2'd0,
    ST_ENTRY  = 2'd1,
    ST_DONE   = 2'd2,
    ST_LOCKED = 2'd3
  } lock_state_e;

  logic               clk_i;
  logic               rst_ni;
  logic               in_valid_i;
  logic               in_ready_o;
  kpl_pkg::in_item_t  in_item_i;
  logic               out_valid_o;
  logic               out_ready_i;
  kpl_pkg::out_item_t out_item_o;
  logic               cfg_valid_i;
  logic               cfg_ready_o;
  logic [1:0]         cfg_index_i;
  logic [31:0]        cfg_data_i;

  keypad_pin_entry_lock_core #(
    .MAX_DIGITS(DIGITS)
  ) dut (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .in_valid_i (in_valid_i),
    .in_ready_o (in_ready_o),
    .in_item_i  (in_item_i),
    .out_valid_o(out_valid_o),
    .out_ready_i(out_ready_i),
    .out_item_o (out_item_o),
    .cfg_valid_i(cfg_valid_i),
    .cfg_ready_o(cfg_ready_o),
    .cfg_index_i(cfg_index_i),
    .cfg_data_i (cfg_data_i)
  );

  // Shadow of the lock: registers and per-session state
  kpl_pkg::cfg_t lock_cfg = '{1'b0, kpl_pkg::PIN_VALUE_RST, kpl_pkg::PIN_LENGTH_RST,
                              kpl_pkg::TRY_LIMIT_RST};
  lock_state_e lock_st = ST_IDLE;
  logic [7:0]  keys_held [DIGITS];
  logic [2:0]  n_held = '0;
  logic [3:0]  wrong_cnt = '0;
  logic        dozing = 1'b0;

  kpl_pkg::in_item_t  key_queue [$];
  kpl_pkg::out_item_t lock_events [$];

  int          idle_max = 12;
  int          in_gap = 0;
  int          out_stall = 0;
  logic        in_taken = 1'b0;
  logic        out_taken = 1'b0;
  int          cycles = 0;
  int          errors = 0;
  int          n_queued = 0;
  int          n_accepted = 0;
  int          n_checked = 0;
  int          n_settings = 0;
  int          ev_seen [16];

  initial begin
    clk_i = 1'b0;
    forever #10 clk_i = ~clk_i;
  end

  function automatic kpl_pkg::out_item_t predict_lock(kpl_pkg::in_item_t it);
    kpl_pkg::ev_e       ev;
    kpl_pkg::out_item_t res;
    logic               hit;
    int                 i;
    ev = kpl_pkg::EV_NONE;
    if (lock_cfg.enable) begin
      case (it.operation)
        kpl_pkg::OP_SESSION: begin
          wrong_cnt = '0;
          n_held = '0;
          lock_st = ST_IDLE;
        end
        kpl_pkg::OP_SLEEP: begin
          dozing = 1'b1;
          if (lock_st == ST_ENTRY) begin
            n_held = '0;
            lock_st = ST_IDLE;
            ev = kpl_pkg::EV_ABORT;
          end
        end
        kpl_pkg::OP_KEY: begin
          if (it.key != kpl_pkg::KEY_NONE) begin
            if (dozing) begin
              dozing = 1'b0;
              ev = kpl_pkg::EV_WOKE;
            end else if (lock_st == ST_IDLE) begin
              if (it.key == kpl_pkg::KEY_D) begin
                ev = kpl_pkg::EV_FACE;
              end else if (it.key == kpl_pkg::KEY_C) begin
                ev = kpl_pkg::EV_FINGER;
              end else if (it.key != kpl_pkg::KEY_HASH && it.key != kpl_pkg::KEY_STAR &&
                           it.key != kpl_pkg::KEY_A && it.key != kpl_pkg::KEY_B) begin
                keys_held[0] = it.key;
                n_held = 3'd1;
                lock_st = ST_ENTRY;
                ev = kpl_pkg::EV_STORED;
              end
            end else if (lock_st == ST_ENTRY) begin
              if (it.key == kpl_pkg::KEY_HASH) begin
                if (n_held != 0) begin
                  hit = (n_held == lock_cfg.pin_length);
                  for (i = 0; i < DIGITS; i++) begin
                    if (i < n_held && keys_held[i] != lock_cfg.pin_value[8*i +: 8]) hit = 1'b0;
                  end
                  n_held = '0;
                  if (hit) begin
                    lock_st = ST_DONE;
                    ev = kpl_pkg::EV_OK;
                  end else begin
                    if (wrong_cnt < kpl_pkg::ATTEMPT_SAT) wrong_cnt = wrong_cnt + 4'd1;
                    if (wrong_cnt >= lock_cfg.try_limit) begin
                      lock_st = ST_LOCKED;
                      ev = kpl_pkg::EV_LOCKED;
                    end else begin
                      lock_st = ST_IDLE;
                      ev = kpl_pkg::EV_WRONG;
                    end
                  end
                end
              end else if (it.key == kpl_pkg::KEY_STAR) begin
                if (n_held != 0) begin
                  n_held = n_held - 3'd1;
                  ev = kpl_pkg::EV_ERASED;
                end
              end else if (it.key < kpl_pkg::KEY_A || it.key > kpl_pkg::KEY_D) begin
                if (n_held < DIGITS) begin
                  keys_held[n_held[1:0]] = it.key;
                  n_held = n_held + 3'd1;
                  ev = kpl_pkg::EV_STORED;
                end
              end
            end
          end
        end
        default: ;
      endcase
    end
    res.event_res = ev;
    res.entry_length = n_held;
    res.tries_left = (lock_cfg.try_limit > wrong_cnt) ? lock_cfg.try_limit - wrong_cnt
                                                      : 4'd0;
    return res;
  endfunction

  function automatic void check_field(string name, int unsigned want, int unsigned got);
    if (want != got) begin
      errors++;
      $display("%0t: %s mismatch, expected %0d, actual %0d", $time, name, want, got);
    end
  endfunction

  // Sampling side: prediction on accepted keys, comparison on accepted results
  always @(posedge clk_i or negedge rst_ni) begin
    kpl_pkg::out_item_t want;
    if (!rst_ni) begin
      in_taken <= 1'b0;
      out_taken <= 1'b0;
    end else begin
      cycles++;
      if (cycles >= LIMIT) begin
        $display("%0t: timeout after %0d cycles, %0d results outstanding", $time, cycles,
                 lock_events.size());
        $display("Test completed with failures");
        $finish;
      end else begin
        in_taken <= in_valid_i && in_ready_o;
        out_taken <= out_valid_o && out_ready_i;
        if (out_valid_o && out_ready_i) begin
          if (lock_events.size() == 0) begin
            errors++;
            $display("%0t: unexpected result, expected none, actual ev=%0d len=%0d tries=%0d",
                     $time, out_item_o.event_res, out_item_o.entry_length,
                     out_item_o.tries_left);
          end else begin
            want = lock_events.pop_front();
            check_field("event_res", want.event_res, out_item_o.event_res);
            check_field("entry_length", want.entry_length, out_item_o.entry_length);
            check_field("tries_left", want.tries_left, out_item_o.tries_left);
            ev_seen[want.event_res]++;
            n_checked++;
          end
        end
        if (in_valid_i && in_ready_o) begin
          lock_events.push_back(predict_lock(in_item_i));
          n_accepted++;
        end
      end
    end
  end

  // Key driver: one transaction per queue entry, random gap after each
  always @(negedge clk_i) begin
    if (rst_ni) begin
      if (in_valid_i && !in_taken) begin
        // held until accepted
      end else if (in_gap > 0) begin
        in_gap <= in_gap - 1;
        in_valid_i <= 1'b0;
      end else if (key_queue.size() > 0) begin
        in_item_i <= key_queue.pop_front();
        in_valid_i <= 1'b1;
        in_gap <= $urandom_range(0, idle_max);
      end else begin
        in_valid_i <= 1'b0;
      end
    end
  end

  // Result sink: random stall after each result
  always @(negedge clk_i) begin
    if (rst_ni) begin
      if (out_taken) out_stall = $urandom_range(0, idle_max);
      if (out_stall > 0) begin
        out_stall--;
        out_ready_i <= 1'b0;
      end else begin
        out_ready_i <= 1'b1;
      end
    end
  end

  task automatic push_item(kpl_pkg::op_e op, logic [7:0] k);
    kpl_pkg::in_item_t it;
    it.operation = op;
    it.key = k;
    key_queue.push_back(it);
    n_queued++;
  endtask

  task automatic push_key(logic [7:0] k);
    push_item(kpl_pkg::OP_KEY, k);
  endtask

  task automatic write_reg(kpl_pkg::cfg_idx_e idx, logic [31:0] data);
    @(negedge clk_i);
    cfg_valid_i <= 1'b1;
    cfg_index_i <= idx;
    cfg_data_i <= data;
    do @(posedge clk_i); while (!cfg_ready_o);
    case (idx)
      kpl_pkg::CFG_ENABLE:     lock_cfg.enable = data[0];
      kpl_pkg::CFG_PIN_VALUE:  lock_cfg.pin_value = data;
      kpl_pkg::CFG_PIN_LENGTH: lock_cfg.pin_length = data[2:0];
      kpl_pkg::CFG_TRY_LIMIT:  lock_cfg.try_limit = data[3:0];
      default: ;
    endcase
    @(negedge clk_i);
    cfg_valid_i <= 1'b0;
  endtask

  task automatic set_lock(logic en, logic [31:0] pin, logic [2:0] len, logic [3:0] tries);
    write_reg(kpl_pkg::CFG_ENABLE, {31'd0, en});
    write_reg(kpl_pkg::CFG_PIN_VALUE, pin);
    write_reg(kpl_pkg::CFG_PIN_LENGTH, {29'd0, len});
    write_reg(kpl_pkg::CFG_TRY_LIMIT, {28'd0, tries});
    n_settings++;
  endtask

  // Block is idle once every queued transaction has returned its result
  task automatic drain();
    do @(negedge clk_i);
    while (key_queue.size() != 0 || in_valid_i || n_checked != n_queued);
    repeat (SETTLE) @(negedge clk_i);
  endtask

  function automatic logic [7:0] entry_key();
    logic [7:0] k;
    if ($urandom_range(0, 3) != 0) begin
      k = 8'(8'h30 + $urandom_range(0, 9));
    end else begin
      do k = 8'($urandom_range(1, 255));
      while (k == kpl_pkg::KEY_HASH || k == kpl_pkg::KEY_STAR ||
             (k >= kpl_pkg::KEY_A && k <= kpl_pkg::KEY_D));
    end
    return k;
  endfunction

  function automatic logic [31:0] make_pin();
    return {entry_key(), entry_key(), entry_key(), entry_key()};
  endfunction

  // PIN attempt: correct keys, or a near miss / wrong length, with the odd erase
  task automatic push_attempt();
    int n;
    int miss;
    int i;
    logic [7:0] k;
    n = int'(lock_cfg.pin_length);
    if (n == 0 || n > DIGITS || $urandom_range(0, 3) == 0) n = $urandom_range(1, DIGITS + 1);
    miss = ($urandom_range(0, 2) == 0) ? $urandom_range(0, n - 1) : -1;
    for (i = 0; i < n; i++) begin
      k = (i < DIGITS) ? lock_cfg.pin_value[8*i +: 8] : entry_key();
      if (i == miss) k = entry_key();
      if ($urandom_range(0, 9) == 0) begin
        push_key(entry_key());
        push_key(kpl_pkg::KEY_STAR);
      end
      push_key(k);
    end
    push_key(kpl_pkg::KEY_HASH);
    if ($urandom_range(0, 2) == 0) push_item(kpl_pkg::OP_SESSION, 8'($urandom_range(0, 255)));
  endtask

  task automatic push_random(int count);
    int first;
    int r;
    first = n_queued;
    while (n_queued - first < count) begin
      r = $urandom_range(0, 99);
      if (r < 60) begin
        push_attempt();
      end else if (r < 70) begin
        push_item(kpl_pkg::OP_SLEEP, 8'($urandom_range(0, 255)));
        push_key(8'($urandom_range(1, 255)));
      end else if (r < 78) begin
        push_item(kpl_pkg::OP_SESSION, 8'($urandom_range(0, 255)));
      end else begin
        push_item(kpl_pkg::op_e'(2'($urandom_range(0, 3))), 8'($urandom_range(0, 255)));
      end
    end
  endtask

  initial begin
    int p;
    logic en;
    logic [2:0] len;
    logic [3:0] tries;
    rst_ni = 1'b0;
    in_valid_i = 1'b0;
    in_item_i = '0;
    out_ready_i = 1'b0;
    cfg_valid_i = 1'b0;
    cfg_index_i = '0;
    cfg_data_i = '0;
    for (p = 0; p < 16; p++) ev_seen[p] = 0;
    repeat (7) @(posedge clk_i);
    @(negedge clk_i);
    rst_ni <= 1'b1;

    // out of reset the lock is disabled: everything ignored
    push_key("1");
    push_item(kpl_pkg::OP_SESSION, 8'h00);
    drain();

    // directed: one-key PIN, single attempt
    set_lock(1'b1, 32'h0000_0031, 3'd1, 4'd1);
    push_key(kpl_pkg::KEY_NONE);
    push_item(kpl_pkg::OP_UNUSED, 8'hFF);
    push_key(kpl_pkg::KEY_HASH);
    push_key(kpl_pkg::KEY_STAR);
    push_key(kpl_pkg::KEY_A);
    push_key(kpl_pkg::KEY_D);
    push_key(kpl_pkg::KEY_C);
    push_key("2");
    push_key(kpl_pkg::KEY_B);
    push_key(kpl_pkg::KEY_STAR);
    push_key(kpl_pkg::KEY_STAR);
    push_key(kpl_pkg::KEY_HASH);
    push_key("1");
    push_key(kpl_pkg::KEY_HASH);
    push_key("5");
    push_item(kpl_pkg::OP_SESSION, 8'h00);
    push_key("2");
    push_key(kpl_pkg::KEY_HASH);
    push_key("3");
    push_item(kpl_pkg::OP_SESSION, 8'hFF);
    push_item(kpl_pkg::OP_SLEEP, 8'h00);
    push_key("9");
    push_key(8'hFF);
    push_item(kpl_pkg::OP_SLEEP, 8'h00);
    push_key("7");
    drain();

    for (p = 0; p < 12; p++) begin
      en = 1'b1;
      len = 3'($urandom_range(1, DIGITS));
      tries = 4'($urandom_range(1, 15));
      case (p)
        0: begin len = 3'd4; tries = 4'd3; end
        1: begin len = 3'd1; tries = 4'd1; end
        2: begin len = 3'd4; tries = 4'd15; end
        3: begin len = 3'd0; tries = 4'd0; end   // never matches, first miss locks
        4: begin len = 3'd7; tries = 4'd2; end   // longer than the buffer
        5: en = 1'b0;
        default: ;
      endcase
      idle_max = (p % 4 == 2) ? 0 : 12;
      set_lock(en, make_pin(), len, tries);
      push_random((p == 5) ? 30 : 130);
      drain();
    end

    $display("Checked %0d results from %0d keypad transactions over %0d lock settings.",
             n_checked, n_accepted, n_settings);
    $display("Events: ok=%0d wrong=%0d locked=%0d stored=%0d erased=%0d woke=%0d aborted=%0d",
             ev_seen[kpl_pkg::EV_OK], ev_seen[kpl_pkg::EV_WRONG], ev_seen[kpl_pkg::EV_LOCKED],
             ev_seen[kpl_pkg::EV_STORED], ev_seen[kpl_pkg::EV_ERASED],
             ev_seen[kpl_pkg::EV_WOKE], ev_seen[kpl_pkg::EV_ABORT]);
    if (errors == 0) begin
      $display("Test completed successfully");
    end else begin
      $display("Test completed with failures");
    end
    $finish;
  end

endmodule

// File: keypad_pin_entry_lock_core.f
hw/rtl/kpl_pkg.sv
hw/rtl/kpl_in_stage.sv
hw/rtl/kpl_fsm.sv
hw/rtl/kpl_out_stage.sv
hw/rtl/keypad_pin_entry_lock_core.sv
hw/rtl/kpl_checker.sv
tb/tb_top.sv
